>>> hdl/pipct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pipct_pkg;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_EVEN    = 2'd0;
  localparam logic [1:0] ST_ODD     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_NO_TP   = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y    = 3'd4;

  localparam int unsigned VCOUNT_W = 7;

  // sign of a*b - c*d, valid in the cycle done is high
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } xp_res_t;

endpackage
`default_nettype wire

>>> hdl/pipct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pipct_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/pipct_xprod.sv
`timescale 1ns / 1ps
`default_nettype none
module pipct_xprod #(
  parameter int unsigned W = 33
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  input  wire logic signed [W-1:0] c_i,
  input  wire logic signed [W-1:0] d_i,
  output pipct_pkg::xp_res_t       res_o
);

  localparam int unsigned ND = (W + 3) / 4;
  localparam int unsigned WP = ND * 4;
  localparam int unsigned AW = 2 * W + 4;
  localparam int unsigned CW = (ND > 1) ? $clog2(ND) : 1;

  logic signed [W-1:0]  a_q, c_q;
  logic signed [WP-1:0] b_q, d_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic [CW-1:0]        cnt_q;
  logic                 run_q, first_q, done_q;
  logic signed [4:0]    dig_b, dig_d;
  logic signed [W+4:0]  pa, pc;

  // radix-16 horner, most significant digit first (that one signed)
  always_comb begin
    dig_b = $signed({first_q ? b_q[WP-1] : 1'b0, b_q[WP-1 -: 4]});
    dig_d = $signed({first_q ? d_q[WP-1] : 1'b0, d_q[WP-1 -: 4]});
    pa    = (W+5)'(a_q) * (W+5)'(dig_b);
    pc    = (W+5)'(c_q) * (W+5)'(dig_d);
    acc_d = (acc_q <<< 4) + AW'(pa) - AW'(pc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q   <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CW'(ND - 1);
      end else if (run_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      c_q   <= c_i;
      b_q   <= WP'(b_i);
      d_q   <= WP'(d_i);
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
      b_q   <= b_q <<< 4;
      d_q   <= d_q <<< 4;
    end
  end

  assign res_o.done = done_q;
  assign res_o.neg  = acc_q[AW-1];
  assign res_o.zero = (acc_q == '0);

endmodule
`default_nettype wire

>>> hdl/pipct_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pipct_div #(
  parameter int unsigned W  = 33,
  parameter int unsigned DW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [W-1:0]  num_x_i,
  input  wire logic [W-1:0]  num_y_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [W-1:0]       quo_x_o,
  output logic [W-1:0]       quo_y_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  nx_q, ny_q;
  logic [DW-1:0] rx_q, ry_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   shx, shy;
  logic          gex, gey;

  // restoring division, one quotient bit per cycle on both lanes
  always_comb begin
    shx = {rx_q, nx_q[W-1]};
    shy = {ry_q, ny_q[W-1]};
    gex = (shx >= (DW+1)'(den_q));
    gey = (shy >= (DW+1)'(den_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      nx_q  <= num_x_i;
      ny_q  <= num_y_i;
      rx_q  <= '0;
      ry_q  <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      nx_q <= {nx_q[W-2:0], gex};
      ny_q <= {ny_q[W-2:0], gey};
      rx_q <= gex ? DW'(shx - (DW+1)'(den_q)) : DW'(shx);
      ry_q <= gey ? DW'(shy - (DW+1)'(den_q)) : DW'(shy);
    end
  end

  assign done_o  = done_q;
  assign quo_x_o = nx_q;
  assign quo_y_o = ny_q;

endmodule
`default_nettype wire

>>> hdl/point_in_polygon_crossing_test.sv
`timescale 1ns / 1ps
`default_nettype none
// point-in-polygon test by crossing parity over a stored vertex list
// command channel: a word is taken when start is high and busy is low;
// opcode_i selects a vertex store (slot vertex_index_i) or a point query
// a store gives no result and leaves busy low; a query gives one result word
// on inside_res_o / status_o, marked by done_o for exactly one cycle
// the receiver cannot stall; done_o rises in the cycle busy falls
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i; the user must
// write it only while busy is low, the block itself does not enforce this
// query steps (n vertices in use):
//   bounding box build (first query only): a memory read and a box update per vertex
//   box check of the query point
//   per divisor tried: a division, then a collinear scan over the vertices
//   crossing count: per edge 2 or 4 a*b-c*d signs in the product unit
// one shared product unit (radix-16, most significant digit first) and one
// bit-serial divider set how long a query keeps the block busy
// reset clears control and config registers, box and sequencer; the payload registers and vertex memory are not cleared
module point_in_polygon_crossing_test #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_DIVISOR  = 5000,
  parameter int unsigned COORD_BITS   = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               opcode_i,
  input  wire logic [5:0]                         vertex_index_i,
  input  wire logic signed [COORD_BITS-1:0]       coord_x_i,
  input  wire logic signed [COORD_BITS-1:0]       coord_y_i,
  output logic                                    done_o,
  output logic                                    inside_res_o,
  output logic [1:0]                              status_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [pipct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]              cfg_data_i
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned W  = CB + 1;
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW = $clog2(MAX_DIVISOR);
  localparam logic [CB-1:0] B_RESET = CB'(65536);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_BOX_RD    = 15'b000000000000010,
    S_BOX_UPD   = 15'b000000000000100,
    S_CHECK     = 15'b000000000001000,
    S_DIV       = 15'b000000000010000,
    S_DIV_WAIT  = 15'b000000000100000,
    S_TP        = 15'b000000001000000,
    S_SRCH_RD   = 15'b000000010000000,
    S_SRCH_GO   = 15'b000000100000000,
    S_SRCH_WAIT = 15'b000001000000000,
    S_EDGE_RDA  = 15'b000010000000000,
    S_EDGE_RDB  = 15'b000100000000000,
    S_EDGE_LD   = 15'b001000000000000,
    S_EDGE_GO   = 15'b010000000000000,
    S_EDGE_WAIT = 15'b100000000000000
  } state_e;

  function automatic logic signed [W-1:0] sdiff(input logic signed [CB-1:0] p,
                                                input logic signed [CB-1:0] m);
    return W'(p) - W'(m);
  endfunction

  state_e state_q, state_d;

  logic [pipct_pkg::VCOUNT_W-1:0] vcount_q;
  logic signed [CB-1:0] ia_x_q, ia_y_q, ib_x_q, ib_y_q;
  logic signed [CB-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
  logic                 box_ready_q;
  logic signed [CB-1:0] qx_q, qy_q, x0_q, y0_q, tx_q, ty_q;
  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [W-1:0]  dfx_q, dfy_q;
  logic [NW-1:0]        n_q, idx_q;
  logic [DW-1:0]        d_q;
  logic [1:0]           mstep_q;
  logic                 sa_neg_q, sa_zero_q, parity_q;
  logic                 done_q, inside_q;
  logic [1:0]           status_q;

  logic [AW-1:0]        raddr;
  logic [2*CB-1:0]      rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  logic                 mem_we;
  logic [NW:0]          idx_nx;
  logic                 idx_last;
  logic [AW-1:0]        jaddr;

  logic                 xp_go;
  logic signed [W-1:0]  xa, xb, xc, xd;
  pipct_pkg::xp_res_t   xp;

  logic                 div_go, div_done;
  logic [W-1:0]         quo_x, quo_y;
  logic signed [W-1:0]  sq_x, sq_y;

  logic                 swap;
  logic [NW-1:0]        n_new;
  logic                 opp, crossed;

  assign busy   = (state_q != S_IDLE);
  assign mem_we = (state_q == S_IDLE) && start && (opcode_i == pipct_pkg::OP_STORE) &&
                  (int'(vertex_index_i) < MAX_VERTICES);

  assign idx_nx   = (NW+1)'(idx_q) + 1'b1;
  assign idx_last = (idx_nx >= (NW+1)'(n_q));
  assign jaddr    = idx_last ? '0 : AW'(idx_nx);

  always_comb begin
    raddr = AW'(idx_q);
    if (state_q == S_EDGE_RDB || state_q == S_EDGE_LD) begin
      raddr = jaddr;
    end
  end

  pipct_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(vertex_index_i)),
    .wdata_i ({coord_x_i, coord_y_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[2*CB-1:CB];
  assign rd_y = rdata[CB-1:0];

  // operand select for the shared product unit
  always_comb begin
    xa = '0;
    xb = '0;
    xc = '0;
    xd = '0;
    if (state_q == S_SRCH_GO) begin
      xa = sdiff(rd_y, ty_q);
      xb = sdiff(tx_q, qx_q);
      xc = sdiff(ty_q, qy_q);
      xd = sdiff(rd_x, tx_q);
    end else begin
      case (mstep_q)
        2'd0: begin
          xa = sdiff(qx_q, tx_q);
          xb = sdiff(ay_q, ty_q);
          xc = sdiff(qy_q, ty_q);
          xd = sdiff(ax_q, tx_q);
        end
        2'd1: begin
          xa = sdiff(qx_q, tx_q);
          xb = sdiff(by_q, ty_q);
          xc = sdiff(qy_q, ty_q);
          xd = sdiff(bx_q, tx_q);
        end
        2'd2: begin
          xa = sdiff(bx_q, ax_q);
          xb = sdiff(ty_q, ay_q);
          xc = sdiff(by_q, ay_q);
          xd = sdiff(tx_q, ax_q);
        end
        default: begin
          xa = sdiff(bx_q, ax_q);
          xb = sdiff(qy_q, ay_q);
          xc = sdiff(by_q, ay_q);
          xd = sdiff(qx_q, ax_q);
        end
      endcase
    end
  end

  assign xp_go = (state_q == S_SRCH_GO) || (state_q == S_EDGE_GO);

  pipct_xprod #(.W(W)) u_xprod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (xp_go),
    .a_i    (xa),
    .b_i    (xb),
    .c_i    (xc),
    .d_i    (xd),
    .res_o  (xp)
  );

  assign div_go = (state_q == S_DIV);

  pipct_div #(.W(W), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (div_go),
    .num_x_i (dfx_q[W-1] ? W'(-dfx_q) : W'(dfx_q)),
    .num_y_i (dfy_q[W-1] ? W'(-dfy_q) : W'(dfy_q)),
    .den_i   (d_q),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  assign sq_x = dfx_q[W-1] ? -$signed(quo_x) : $signed(quo_x);
  assign sq_y = dfy_q[W-1] ? -$signed(quo_y) : $signed(quo_y);

  assign swap  = (ia_x_q == ib_x_q) ? (ib_y_q < ia_y_q) : (ib_x_q < ia_x_q);
  assign n_new = (int'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);
  assign opp   = !sa_zero_q && !xp.zero && (sa_neg_q != xp.neg);
  assign crossed = sa_zero_q || xp.zero || (sa_neg_q != xp.neg);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && opcode_i == pipct_pkg::OP_QUERY) begin
          state_d = box_ready_q ? S_CHECK : S_BOX_RD;
        end
      end
      S_BOX_RD:  state_d = S_BOX_UPD;
      S_BOX_UPD: state_d = idx_last ? S_CHECK : S_BOX_RD;
      S_CHECK: begin
        if (qx_q < bmin_x_q || qx_q > bmax_x_q || qy_q < bmin_y_q || qy_q > bmax_y_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:      state_d = S_DIV_WAIT;
      S_DIV_WAIT: state_d = div_done ? S_TP : S_DIV_WAIT;
      S_TP: begin
        if (tx_q == qx_q && ty_q == qy_q) begin
          state_d = (d_q == DW'(MAX_DIVISOR - 1)) ? S_IDLE : S_DIV;
        end else if (n_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: state_d = S_SRCH_GO;
      S_SRCH_GO: state_d = S_SRCH_WAIT;
      S_SRCH_WAIT: begin
        if (xp.done) begin
          if (xp.zero) begin
            state_d = (d_q == DW'(MAX_DIVISOR - 1)) ? S_IDLE : S_DIV;
          end else begin
            state_d = idx_last ? S_EDGE_RDA : S_SRCH_RD;
          end
        end
      end
      S_EDGE_RDA: state_d = S_EDGE_RDB;
      S_EDGE_RDB: state_d = S_EDGE_LD;
      S_EDGE_LD:  state_d = S_EDGE_GO;
      S_EDGE_GO:  state_d = S_EDGE_WAIT;
      S_EDGE_WAIT: begin
        if (xp.done) begin
          if ((mstep_q == 2'd1 && !opp) || mstep_q == 2'd3) begin
            state_d = idx_last ? S_IDLE : S_EDGE_RDA;
          end else begin
            state_d = S_EDGE_GO;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= '0;
      ia_x_q      <= '0;
      ia_y_q      <= '0;
      ib_x_q      <= B_RESET;
      ib_y_q      <= B_RESET;
      bmin_x_q    <= '0;
      bmax_x_q    <= '0;
      bmin_y_q    <= '0;
      bmax_y_q    <= '0;
      box_ready_q <= 1'b0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      d_q         <= '0;
      mstep_q     <= '0;
      parity_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pipct_pkg::REG_VCOUNT: vcount_q <= cfg_data_i[pipct_pkg::VCOUNT_W-1:0];
          pipct_pkg::REG_A_X:    ia_x_q   <= cfg_data_i;
          pipct_pkg::REG_A_Y:    ia_y_q   <= cfg_data_i;
          pipct_pkg::REG_B_X:    ib_x_q   <= cfg_data_i;
          pipct_pkg::REG_B_Y:    ib_y_q   <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
        end
        S_BOX_UPD: begin
          if (idx_q == '0) begin
            bmin_x_q <= rd_x;
            bmax_x_q <= rd_x;
            bmin_y_q <= rd_y;
            bmax_y_q <= rd_y;
          end else begin
            if (rd_x < bmin_x_q) bmin_x_q <= rd_x;
            if (rd_x > bmax_x_q) bmax_x_q <= rd_x;
            if (rd_y < bmin_y_q) bmin_y_q <= rd_y;
            if (rd_y > bmax_y_q) bmax_y_q <= rd_y;
          end
          if (idx_last) begin
            box_ready_q <= 1'b1;
          end else begin
            idx_q <= NW'(idx_nx);
          end
        end
        S_CHECK: begin
          d_q <= DW'(1);
          if (state_d == S_IDLE) begin
            done_q <= 1'b1;
          end
        end
        S_DIV: begin
          idx_q <= '0;
        end
        S_TP: begin
          if (tx_q == qx_q && ty_q == qy_q) begin
            d_q <= d_q + 1'b1;
          end
          if (state_d == S_IDLE) begin
            done_q <= 1'b1;
          end
        end
        S_SRCH_WAIT: begin
          if (xp.done) begin
            if (xp.zero) begin
              d_q <= d_q + 1'b1;
              if (state_d == S_IDLE) begin
                done_q <= 1'b1;
              end
            end else if (idx_last) begin
              idx_q    <= '0;
              parity_q <= 1'b0;
            end else begin
              idx_q <= NW'(idx_nx);
            end
          end
        end
        S_EDGE_LD: begin
          mstep_q <= '0;
        end
        S_EDGE_WAIT: begin
          if (xp.done) begin
            if (state_d == S_EDGE_GO) begin
              mstep_q <= mstep_q + 1'b1;
            end else begin
              if (mstep_q == 2'd3) begin
                parity_q <= parity_q ^ crossed;
              end
              if (idx_last) begin
                done_q <= 1'b1;
              end else begin
                idx_q <= NW'(idx_nx);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        qx_q  <= coord_x_i;
        qy_q  <= coord_y_i;
        n_q   <= n_new;
        x0_q  <= swap ? ib_x_q : ia_x_q;
        y0_q  <= swap ? ib_y_q : ia_y_q;
        dfx_q <= swap ? sdiff(ia_x_q, ib_x_q) : sdiff(ib_x_q, ia_x_q);
        dfy_q <= swap ? sdiff(ia_y_q, ib_y_q) : sdiff(ib_y_q, ia_y_q);
      end
      S_CHECK: begin
        inside_q <= 1'b0;
        status_q <= pipct_pkg::ST_OUTSIDE;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          tx_q <= CB'(W'(x0_q) + sq_x);
          ty_q <= CB'(W'(y0_q) + sq_y);
        end
      end
      S_TP: begin
        if (tx_q == qx_q && ty_q == qy_q) begin
          inside_q <= 1'b1;
          status_q <= pipct_pkg::ST_NO_TP;
        end else begin
          inside_q <= 1'b1;
          status_q <= pipct_pkg::ST_EVEN;
        end
      end
      S_SRCH_WAIT: begin
        inside_q <= 1'b1;
        status_q <= pipct_pkg::ST_NO_TP;
      end
      S_EDGE_RDB: begin
        ax_q <= rd_x;
        ay_q <= rd_y;
      end
      S_EDGE_LD: begin
        bx_q <= rd_x;
        by_q <= rd_y;
      end
      S_EDGE_WAIT: begin
        if (xp.done) begin
          if (mstep_q == 2'd0 || mstep_q == 2'd2) begin
            sa_neg_q  <= xp.neg;
            sa_zero_q <= xp.zero;
          end
          if ((mstep_q == 2'd3 ? parity_q ^ crossed : parity_q)) begin
            inside_q <= 1'b0;
            status_q <= pipct_pkg::ST_ODD;
          end else begin
            inside_q <= 1'b1;
            status_q <= pipct_pkg::ST_EVEN;
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;
  assign status_o     = status_q;

endmodule
`default_nettype wire

>>> hdl/pipct_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module pipct_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       opcode_i,
  input wire logic       done_o,
  input wire logic       inside_res_o,
  input wire logic [1:0] status_o
);

  // a result word ends the query
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

  // a store finishes at once and gives no result
  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == pipct_pkg::OP_STORE) |=> (!busy && !done_o))
    else $error("store left the block busy or gave a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == pipct_pkg::OP_QUERY) |=> (busy && !done_o))
    else $error("query not taken up");

  a_inside_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (inside_res_o ==
               (status_o == pipct_pkg::ST_EVEN || status_o == pipct_pkg::ST_NO_TP)))
    else $error("inside flag disagrees with status");

endmodule

bind point_in_polygon_crossing_test pipct_chk u_pipct_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .opcode_i     (opcode_i),
  .done_o       (done_o),
  .inside_res_o (inside_res_o),
  .status_o     (status_o)
);
`default_nettype wire

>>> test/pipct_checker.sv
`timescale 1ns / 1ps
module pipct_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               opcode_i,
  input  logic [5:0]         vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic               cfg_we_i,
  input  logic [pipct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               done_i,
  input  logic               inside_res_i,
  input  logic [1:0]         status_i,
  output int                 errors_o,
  output int                 pending_o
);
  import pipct_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int DIV_LIMIT = 5000;

  typedef struct packed {
    logic       in_poly;
    logic [1:0] status;
  } verdict_t;

  verdict_t  expected_verdicts[$];
  longint    slot_x[NUM_SLOTS];
  longint    slot_y[NUM_SLOTS];
  longint    bmin_x, bmax_x, bmin_y, bmax_y;
  logic      box_valid;
  logic [6:0] vcount;
  longint    ia_x, ia_y, ib_x, ib_y;
  int        mismatches;

  assign errors_o  = mismatches;
  assign pending_o = expected_verdicts.size();

  // sign of a*b - c*d, exact
  function automatic int prod_diff_sign(longint a, longint b, longint c, longint d);
    logic signed [127:0] wa, wb, wc, wd, p;
    wa = a; wb = b; wc = c; wd = d;
    p = wa * wb - wc * wd;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  function automatic logic edge_hit(longint tx, longint ty, longint qx, longint qy,
                                    longint ax, longint ay, longint bx, longint by);
    int sa, sb, o1, o2;
    sa = prod_diff_sign(qx - tx, ay - ty, qy - ty, ax - tx);
    sb = prod_diff_sign(qx - tx, by - ty, qy - ty, bx - tx);
    if (!((sa > 0 && sb < 0) || (sa < 0 && sb > 0))) return 1'b0;
    o1 = prod_diff_sign(bx - ax, ty - ay, by - ay, tx - ax);
    o2 = prod_diff_sign(bx - ax, qy - ay, by - ay, qx - ax);
    return (o1 * o2 <= 0);
  endfunction

  function automatic verdict_t classify_point(longint qx, longint qy);
    verdict_t v;
    int n, i, j, crossings;
    longint x0, y0, x1, y1, tx, ty, d;
    logic found, bad;
    n = (vcount > NUM_SLOTS) ? NUM_SLOTS : int'(vcount);
    found = 1'b0;
    tx = 0;
    ty = 0;
    crossings = 0;
    if (!box_valid) begin
      bmin_x = slot_x[0]; bmax_x = slot_x[0];
      bmin_y = slot_y[0]; bmax_y = slot_y[0];
      for (i = 0; i < n; i++) begin
        if (slot_x[i] < bmin_x) bmin_x = slot_x[i];
        if (slot_x[i] > bmax_x) bmax_x = slot_x[i];
        if (slot_y[i] < bmin_y) bmin_y = slot_y[i];
        if (slot_y[i] > bmax_y) bmax_y = slot_y[i];
      end
      box_valid = 1'b1;
    end
    if (!(bmin_x <= qx && qx <= bmax_x && bmin_y <= qy && qy <= bmax_y)) begin
      v.in_poly = 1'b0;
      v.status = ST_OUTSIDE;
      return v;
    end
    // lower-x (then lower-y) interior point is the origin of the search
    if ((ia_x == ib_x) ? (ib_y < ia_y) : (ib_x < ia_x)) begin
      x0 = ib_x; y0 = ib_y; x1 = ia_x; y1 = ia_y;
    end else begin
      x0 = ia_x; y0 = ia_y; x1 = ib_x; y1 = ib_y;
    end
    for (d = 1; d < DIV_LIMIT && !found; d++) begin
      tx = x0 + (x1 - x0) / d;
      ty = y0 + (y1 - y0) / d;
      if (tx == qx && ty == qy) continue;
      bad = 1'b0;
      for (i = 0; i < n && !bad; i++)
        if (prod_diff_sign(slot_y[i] - ty, tx - qx, ty - qy, slot_x[i] - tx) == 0)
          bad = 1'b1;
      found = !bad;
    end
    if (!found) begin
      v.in_poly = 1'b1;
      v.status = ST_NO_TP;
      return v;
    end
    for (i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      if (edge_hit(tx, ty, qx, qy, slot_x[i], slot_y[i], slot_x[j], slot_y[j]))
        crossings++;
    end
    v.in_poly = ~crossings[0];
    v.status = crossings[0] ? ST_ODD : ST_EVEN;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      expected_verdicts.delete();
      foreach (slot_x[k]) begin
        slot_x[k] = 0;
        slot_y[k] = 0;
      end
      bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0;
      box_valid = 1'b0;
      vcount = '0;
      ia_x = 0; ia_y = 0; ib_x = 65536; ib_y = 65536;
    end else begin
      if (done_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (inside %0b status %0d)",
                                    inside_res_i, status_i));
        end else begin
          want = expected_verdicts.pop_front();
          if (inside_res_i !== want.in_poly)
            report_mismatch($sformatf("inside_res %0b, expected %0b", inside_res_i,
                                      want.in_poly));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VCOUNT: vcount = cfg_data_i[6:0];
          REG_A_X:    ia_x = longint'(signed'(cfg_data_i));
          REG_A_Y:    ia_y = longint'(signed'(cfg_data_i));
          REG_B_X:    ib_x = longint'(signed'(cfg_data_i));
          REG_B_Y:    ib_y = longint'(signed'(cfg_data_i));
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (opcode_i == OP_STORE) begin
          slot_x[vertex_index_i] = coord_x_i;
          slot_y[vertex_index_i] = coord_y_i;
        end else begin
          expected_verdicts.push_back(classify_point(coord_x_i, coord_y_i));
        end
      end
    end
  end
endmodule

>>> test/point_in_polygon_crossing_test_test.sv
`timescale 1ns / 1ps
module point_in_polygon_crossing_test_test;
  import pipct_pkg::*;

  localparam longint CMIN = -64'sd2147483648;
  localparam longint CMAX = 64'sd2147483647;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = REG_B_Y + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = REG_B_Y + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = REG_B_Y + 3'd3;
  localparam int TARGET_WORDS = 950;
  localparam longint CYCLE_LIMIT = 8000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode_i = OP_STORE;
  logic [5:0]         vertex_index_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic               done_o, inside_res_o;
  logic [1:0]         status_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_VCOUNT;
  logic [31:0]        cfg_data_i = '0;
  int                 errors, pending;

  longint poly_x[64], poly_y[64];
  longint pa_x = 0, pa_y = 0, pb_x = 65536, pb_y = 65536;
  int     n_used = 0;
  int     words_sent = 0, queries_sent = 0, settings_used = 0;
  longint cycles = 0;

  always #1 clk_i = ~clk_i;

  point_in_polygon_crossing_test i_dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .vertex_index_i, .coord_x_i, .coord_y_i,
    .done_o, .inside_res_o, .status_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  pipct_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i, .vertex_index_i,
    .coord_x_i, .coord_y_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_i(done_o), .inside_res_i(inside_res_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending);
      $display("point_in_polygon_crossing_test_test: FAIL");
      $finish;
    end
  end

  function automatic longint clip(longint v);
    return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
  endfunction

  function automatic logic collinear(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
    logic signed [127:0] a, b, c, d;
    a = qx - px; b = ry - py; c = qy - py; d = rx - px;
    return (a * b == c * d);
  endfunction

  // queries that would run the whole divisor search are kept rare and directed
  function automatic logic slow_query(longint qx, longint qy);
    logic same_ab;
    same_ab = (pa_x == pb_x) && (pa_y == pb_y);
    if (same_ab && qx == pa_x && qy == pa_y) return 1'b1;
    for (int i = 0; i < n_used; i++) begin
      if (poly_x[i] == qx && poly_y[i] == qy) return 1'b1;
      if (same_ab && collinear(qx, qy, pa_x, pa_y, poly_x[i], poly_y[i])) return 1'b1;
      if (!same_ab && collinear(pa_x, pa_y, pb_x, pb_y, qx, qy) &&
          collinear(pa_x, pa_y, pb_x, pb_y, poly_x[i], poly_y[i])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // word stays on the bus until taken; start only drops when a gap follows
  task automatic send_word(logic op, logic [5:0] idx, longint x, longint y, int gap);
    start <= 1'b1;
    opcode_i <= op;
    vertex_index_i <= idx;
    coord_x_i <= x[31:0];
    coord_y_i <= y[31:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    if (op == OP_STORE) begin
      poly_x[idx] = x;
      poly_y[idx] = y;
    end else begin
      queries_sent++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic store_vertex(int idx, longint x, longint y);
    send_word(OP_STORE, idx[5:0], x, y, next_gap());
  endtask

  task automatic query_point(longint x, longint y);
    send_word(OP_QUERY, '0, x, y, next_gap());
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[31:0];
    @(posedge clk_i);
  endtask

  task automatic set_interior(longint ax, longint ay, longint bx, longint by);
    cfg_write(REG_A_X, ax);
    cfg_write(REG_A_Y, ay);
    cfg_write(REG_B_X, bx);
    cfg_write(REG_B_Y, by);
    cfg_we_i <= 1'b0;
    pa_x = ax; pa_y = ay; pb_x = bx; pb_y = by;
    settings_used++;
  endtask

  task automatic set_count(int value);
    cfg_write(REG_VCOUNT, value);
    cfg_we_i <= 1'b0;
    n_used = (value > 64) ? 64 : value;
    settings_used++;
  endtask

  task automatic random_phase();
    int     shift, r, nq, cfg_n;
    longint cx, cy, span, qx, qy;
    r = $urandom_range(0, 99);
    if (r < 80)      cfg_n = $urandom_range(3, 8);
    else if (r < 88) cfg_n = $urandom_range(0, 2);
    else if (r < 95) cfg_n = $urandom_range(9, 20);
    else             cfg_n = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(65, 127);
    case ($urandom_range(0, 3))
      0: shift = 4;
      1: shift = 12;
      2: shift = 20;
      default: shift = 28;
    endcase
    span = longint'(1) << shift;
    cx = longint'($urandom_range(0, 32'h7fffffff)) - 64'sd1073741824;
    cy = longint'($urandom_range(0, 32'h7fffffff)) - 64'sd1073741824;
    wait_idle();
    set_count(cfg_n);
    qx = clip(cx + longint'($urandom_range(0, 2 * span)) - span);
    qy = clip(cy + longint'($urandom_range(0, 2 * span)) - span);
    r = $urandom_range(0, 9);
    if (r == 0 && shift >= 20) set_interior(qx, qy, qx, qy);
    else if (r == 1) set_interior(qx, qy, qx, clip(qy - span / 2 - 1));
    else set_interior(qx, qy, clip(cx + longint'($urandom_range(0, span)) - span / 2),
                      clip(cy + longint'($urandom_range(0, span)) - span / 2));
    for (int i = 0; i < n_used; i++)
      store_vertex(i, clip(cx + longint'($urandom_range(0, 4 * span)) - 2 * span),
                   clip(cy + longint'($urandom_range(0, 4 * span)) - 2 * span));
    nq = $urandom_range(3, 12);
    for (int k = 0; k < nq; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // stray store into any slot, polygon changes under the stale box
        store_vertex($urandom_range(0, 63),
                     clip(cx + longint'($urandom_range(0, 4 * span)) - 2 * span),
                     clip(cy + longint'($urandom_range(0, 4 * span)) - 2 * span));
        continue;
      end
      qx = clip(cx + longint'($urandom_range(0, 6 * span)) - 3 * span);
      qy = clip(cy + longint'($urandom_range(0, 6 * span)) - 3 * span);
      if (r < 14) qx = CMAX;
      else if (r < 18) qy = CMIN;
      while (slow_query(qx, qy)) qx = (qx == CMAX) ? qx - 1 : qx + 1;
      query_point(qx, qy);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot written once so no query reads an empty one
    set_count(4);
    for (int i = 0; i < 64; i++)
      store_vertex(i, longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))));
    // box fixed by the first query: x up to CMAX-1, y from CMIN+1
    store_vertex(0, CMIN, CMIN + 1);
    store_vertex(1, CMAX - 1, CMIN + 1);
    store_vertex(2, CMAX - 1, CMAX);
    store_vertex(3, CMIN, CMAX);
    query_point(0, 0);
    query_point(CMAX, 0);
    query_point(0, CMIN);
    query_point(CMIN, 5);
    query_point(-1, -1);
    query_point(CMAX - 1, 12345);
    query_point(64'sh55555555, -64'sd1431655766);

    wait_idle();
    cfg_write(REG_SPARE_0, -1);
    cfg_write(REG_SPARE_1, -1);
    cfg_write(REG_SPARE_2, -1);
    cfg_we_i <= 1'b0;
    set_count(127);
    query_point(0, 0);
    query_point(1000, -1000);
    wait_idle();
    set_count(0);
    query_point(7, 7);
    wait_idle();
    set_count(1);
    query_point(7, 7);
    wait_idle();
    set_count(2);
    query_point(9, -3);

    // coincident interior points, one query on them exhausts the search
    wait_idle();
    set_count(3);
    set_interior(5, 5, 5, 5);
    store_vertex(0, -1000, -1000);
    store_vertex(1, 1000, -1000);
    store_vertex(2, 0, 1000);
    query_point(5, 5);
    query_point(100, 3);
    query_point(3000, 0);
    wait_idle();
    set_interior(10, 50, 10, -50);
    query_point(0, 0);
    query_point(-500, 900);
    wait_idle();
    set_interior(200, 0, -200, 0);
    query_point(0, 300);
    query_point(1, -999);
    wait_idle();
    set_interior(CMAX, CMAX, CMIN, CMIN);
    query_point(0, 1);

    while (words_sent < TARGET_WORDS) random_phase();

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d words (%0d point queries) over %0d register settings",
             words_sent, queries_sent, settings_used);
    $display("%0d mismatches, %0d results never arrived", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("point_in_polygon_crossing_test_test: PASS");
    end else begin
      $display("point_in_polygon_crossing_test_test: FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/pipct_pkg.sv
hdl/pipct_ram.sv
hdl/pipct_xprod.sv
hdl/pipct_div.sv
hdl/point_in_polygon_crossing_test.sv
hdl/pipct_chk.sv
test/pipct_checker.sv
test/point_in_polygon_crossing_test_test.sv
